// ----- rtl/core/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

   localparam int TAYLOR_TERMS = 24;
   localparam int QUO_BITS     = 32;
   localparam int DIV_STAGES   = QUO_BITS + 1;
   localparam int NUM_W        = 56;
   localparam int DEN_W        = 33;

   localparam logic [31:0] Q30_ONE = 32'h4000_0000;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DEPTH = 2'd1,
      STATUS_SINE  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [15:0] fov;
      logic        [15:0] aspect;
      logic signed [31:0] near_plane;
      logic signed [31:0] far_plane;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] m11;
      logic signed [31:0] m22;
      logic signed [31:0] m33;
      logic signed [31:0] m43;
   } rsp_type;

   // one slice of the sine/cosine series
   typedef struct packed {
      logic               valid;
      logic        [31:0] a;
      logic        [31:0] t;
      logic signed [35:0] cs;
      logic signed [35:0] sn;
   } trig_type;

   // per-request values carried alongside the series
   typedef struct packed {
      logic        fneg;
      logic [15:0] asp;
      logic        depth_bad;
      logic        qneg;
      logic [31:0] farmag;
      logic [32:0] dmag;
      logic [31:0] nm;
      logic        nneg;
   } side_type;

   // per-request values carried alongside the dividers
   typedef struct packed {
      status_type  status;
      logic        hneg;
      logic        qneg;
      logic [31:0] nm;
      logic        nneg;
   } post_type;

   // floor(2^32 / n)
   function automatic logic [32:0] recip(input logic [4:0] n);
      logic [32:0] r;
      unique case (n)
         5'd1:    r = 33'd4294967296;
         5'd2:    r = 33'd2147483648;
         5'd3:    r = 33'd1431655765;
         5'd4:    r = 33'd1073741824;
         5'd5:    r = 33'd858993459;
         5'd6:    r = 33'd715827882;
         5'd7:    r = 33'd613566756;
         5'd8:    r = 33'd536870912;
         5'd9:    r = 33'd477218588;
         5'd10:   r = 33'd429496729;
         5'd11:   r = 33'd390451572;
         5'd12:   r = 33'd357913941;
         5'd13:   r = 33'd330382099;
         5'd14:   r = 33'd306783378;
         5'd15:   r = 33'd286331153;
         5'd16:   r = 33'd268435456;
         5'd17:   r = 33'd252645135;
         5'd18:   r = 33'd238609294;
         5'd19:   r = 33'd226050910;
         5'd20:   r = 33'd214748364;
         5'd21:   r = 33'd204522252;
         5'd22:   r = 33'd195225786;
         5'd23:   r = 33'd186737708;
         5'd24:   r = 33'd178956970;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat_pack(input logic neg, input logic [32:0] mag);
      logic [31:0] res;
      if (neg) begin
         res = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - mag);
      end else begin
         res = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/perspective_projection_setup.sv -----
`default_nettype none

// Perspective projection set-up, left-handed.
// A request (fov Q3.13, aspect Q8.8, near and far planes Q16.16) is taken
// at a rising edge with start high and busy low. busy never rises: one
// request may be issued every cycle.
// The response appears on rsp_data, with rsp_valid high for
// one cycle: m22 = cot(fov/2), m11 = m22 * aspect, m33 = far/(far-near),
// m43 = -m33*near, all Q16.16 saturating, plus a status code. On a
// depth-range or half-angle-sine error the four matrix entries are zero.
// Pipeline: 1 input stage, 72 stages of sine/cosine series (three per term,
// 24 terms, each with three multipliers), 1 setup stage, 33 stages of
// bit-per-stage restoring dividers, 3 output stages.
// Throughput is one request per cycle. The receiver cannot stall; every
// response is presented exactly once.
// A synchronous reset drops all requests in flight; no response follows
// a request whose window spans reset.

module perspective_projection_setup
   import pps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int SideDepth = 3 * TAYLOR_TERMS;
   localparam int Latency   = 1 + SideDepth + 1 + DIV_STAGES + 3;

   logic     in_valid_ff;
   req_type  in_req_ff;

   logic        fneg;
   logic [15:0] fmag;
   logic [32:0] d, dmag;
   logic        farneg;
   side_type    side;
   side_type    side_line_ff [0:SideDepth-1];

   trig_type chain [0:TAYLOR_TERMS];

   assign busy = 1'b0;

   always_comb begin
      fneg   = in_req_ff.fov[15];
      fmag   = fneg ? 16'(16'd0 - in_req_ff.fov) : in_req_ff.fov;
      d      = {in_req_ff.far_plane[31], in_req_ff.far_plane}
             - {in_req_ff.near_plane[31], in_req_ff.near_plane};
      dmag   = d[32] ? 33'd0 - d : d;
      farneg = in_req_ff.far_plane[31];

      side.fneg      = fneg;
      side.asp       = in_req_ff.aspect;
      side.depth_bad = (40'(dmag) * 40'd100) < 40'h1_0000;
      side.qneg      = farneg ^ d[32];
      side.farmag    = farneg ? 32'd0 - in_req_ff.far_plane : in_req_ff.far_plane;
      side.dmag      = dmag;
      side.nneg      = in_req_ff.near_plane[31];
      side.nm        = side.nneg ? 32'd0 - in_req_ff.near_plane : in_req_ff.near_plane;

      chain[0].valid = in_valid_ff;
      chain[0].a     = {fmag, 16'b0};
      chain[0].t     = Q30_ONE;
      chain[0].cs    = 36'(Q30_ONE);
      chain[0].sn    = '0;
   end

   for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
      pps_taylor_term u_term (
         .clock      (clock),
         .reset      (reset),
         .term_index (5'(k + 1)),
         .in_term    (chain[k]),
         .out_term   (chain[k+1])
      );
   end

   // setup stage after the series
   trig_type    tr;
   side_type    sd;
   logic        snneg, cneg, sine_bad;
   logic [35:0] sabs, cabs;
   logic [31:0] smag, cmag;
   post_type    post;

   logic        p0_valid_ff;
   post_type    p0_post_ff;
   logic [31:0] p0_cmag_ff, p0_smag_ff, p0_farmag_ff;
   logic [32:0] p0_dmag_ff;
   logic [47:0] p0_wprod_ff;

   always_comb begin
      tr       = chain[TAYLOR_TERMS];
      sd       = side_line_ff[SideDepth-1];
      snneg    = tr.sn[35];
      cneg     = tr.cs[35];
      sabs     = snneg ? 36'd0 - tr.sn : tr.sn;
      cabs     = cneg ? 36'd0 - tr.cs : tr.cs;
      smag     = sabs[31:0];
      cmag     = cabs[31:0];
      sine_bad = (40'(smag) * 40'd100) < 40'(Q30_ONE);

      if (sd.depth_bad) begin
         post.status = STATUS_DEPTH;
      end else if (sine_bad) begin
         post.status = STATUS_SINE;
      end else begin
         post.status = STATUS_OK;
      end
      post.hneg = cneg ^ sd.fneg ^ snneg;
      post.qneg = sd.qneg;
      post.nm   = sd.nm;
      post.nneg = sd.nneg;
   end

   post_type post_line_ff [0:DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         p0_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
         p0_valid_ff <= tr.valid;
      end
      in_req_ff       <= req_data;
      side_line_ff[0] <= side;
      for (int s = 1; s < SideDepth; s++) side_line_ff[s] <= side_line_ff[s-1];
      p0_post_ff   <= post;
      p0_cmag_ff   <= cmag;
      p0_smag_ff   <= smag;
      p0_farmag_ff <= sd.farmag;
      p0_dmag_ff   <= sd.dmag;
      p0_wprod_ff  <= 48'(cmag) * 48'(sd.asp);
      post_line_ff[0] <= p0_post_ff;
      for (int s = 1; s < DIV_STAGES; s++) post_line_ff[s] <= post_line_ff[s-1];
   end

   logic            div_valid;
   logic [QUO_BITS:0] h_quo, w_quo, q_quo;

   pps_divider u_div_h (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p0_valid_ff),
      .num       (NUM_W'({p0_cmag_ff, 16'b0})),
      .den       (DEN_W'(p0_smag_ff)),
      .out_valid (div_valid),
      .quo       (h_quo)
   );

   pps_divider u_div_w (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p0_valid_ff),
      .num       ({p0_wprod_ff, 8'b0}),
      .den       (DEN_W'(p0_smag_ff)),
      .out_valid (),
      .quo       (w_quo)
   );

   pps_divider u_div_q (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p0_valid_ff),
      .num       (NUM_W'({p0_farmag_ff, 16'b0})),
      .den       (p0_dmag_ff),
      .out_valid (),
      .quo       (q_quo)
   );

   // pack, then depth offset multiply, then output register
   post_type    pd;
   logic [31:0] m33_c;

   logic        p2_valid_ff, p3_valid_ff, rsp_valid_ff;
   status_type  p2_status_ff, p3_status_ff;
   logic [31:0] p2_m11_ff, p2_m22_ff, p2_m33_ff, p3_m11_ff, p3_m22_ff, p3_m33_ff;
   logic [31:0] p2_qm_ff, p2_nm_ff;
   logic        p2_oneg_ff, p3_oneg_ff;
   logic [63:0] p3_prod_ff;
   rsp_type     rsp_in, rsp_ff;

   assign pd    = post_line_ff[DIV_STAGES-1];
   assign m33_c = sat_pack(pd.qneg, q_quo);

   always_comb begin
      rsp_in.status = p3_status_ff;
      rsp_in.m11    = p3_m11_ff;
      rsp_in.m22    = p3_m22_ff;
      rsp_in.m33    = p3_m33_ff;
      rsp_in.m43    = sat_pack(p3_oneg_ff, {|p3_prod_ff[63:48], p3_prod_ff[47:16]});
      if (p3_status_ff != STATUS_OK) begin
         rsp_in.m11 = '0;
         rsp_in.m22 = '0;
         rsp_in.m33 = '0;
         rsp_in.m43 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff  <= div_valid;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= p3_valid_ff;
      end
      p2_status_ff <= pd.status;
      p2_m11_ff    <= sat_pack(pd.hneg, w_quo);
      p2_m22_ff    <= sat_pack(pd.hneg, h_quo);
      p2_m33_ff    <= m33_c;
      p2_qm_ff     <= m33_c[31] ? 32'd0 - m33_c : m33_c;
      p2_nm_ff     <= pd.nm;
      p2_oneg_ff   <= !(m33_c[31] ^ pd.nneg);
      p3_status_ff <= p2_status_ff;
      p3_m11_ff    <= p2_m11_ff;
      p3_m22_ff    <= p2_m22_ff;
      p3_m33_ff    <= p2_m33_ff;
      p3_oneg_ff   <= p2_oneg_ff;
      p3_prod_ff   <= 64'(p2_qm_ff) * 64'(p2_nm_ff);
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##Latency rsp_valid)
      else $error("request did not produce a response at the expected latency");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.m11 == 0 && rsp_data.m22 == 0 && rsp_data.m33 == 0 && rsp_data.m43 == 0)
      else $error("matrix entries not cleared on error status");

   a_scale_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.m11 != 0 && rsp_data.m22 != 0
         |-> rsp_data.m11[31] == rsp_data.m22[31])
      else $error("horizontal and vertical scale differ in sign");

endmodule

`default_nettype wire

// ----- rtl/core/pps_taylor_term.sv -----
`default_nettype none

module pps_taylor_term
   import pps_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic [4:0] term_index,
   input  wire trig_type in_term,
   output trig_type      out_term
);

   trig_type    st1_ff, st2_ff, out_ff;
   logic [32:0] x1_ff, x2_ff, q0_ff;

   logic [63:0] ta;
   logic [65:0] xr;
   logic [34:0] qn, r0, r1;
   logic [32:0] q1, q2;
   trig_type    out_in;

   assign ta = 64'(in_term.t) * 64'(in_term.a);
   assign xr = 66'(x1_ff) * 66'(recip(term_index));

   // reciprocal quotient is low by at most two
   always_comb begin
      qn = 35'(q0_ff) * 35'(term_index);
      r0 = 35'(x2_ff) - qn;
      if (r0 >= 35'(term_index)) begin
         q1 = q0_ff + 33'd1;
         r1 = r0 - 35'(term_index);
      end else begin
         q1 = q0_ff;
         r1 = r0;
      end
      q2 = (r1 >= 35'(term_index)) ? q1 + 33'd1 : q1;

      out_in   = st2_ff;
      out_in.t = q2[31:0];
      case (term_index[1:0])
         2'd0:    out_in.cs = st2_ff.cs + 36'(q2[31:0]);
         2'd1:    out_in.sn = st2_ff.sn + 36'(q2[31:0]);
         2'd2:    out_in.cs = st2_ff.cs - 36'(q2[31:0]);
         default: out_in.sn = st2_ff.sn - 36'(q2[31:0]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff.valid <= 1'b0;
         st2_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         st1_ff.valid <= in_term.valid;
         st2_ff.valid <= st1_ff.valid;
         out_ff.valid <= out_in.valid;
      end
      st1_ff.a  <= in_term.a;
      st1_ff.t  <= in_term.t;
      st1_ff.cs <= in_term.cs;
      st1_ff.sn <= in_term.sn;
      x1_ff     <= ta[62:30];
      st2_ff.a  <= st1_ff.a;
      st2_ff.t  <= st1_ff.t;
      st2_ff.cs <= st1_ff.cs;
      st2_ff.sn <= st1_ff.sn;
      x2_ff     <= x1_ff;
      q0_ff     <= xr[64:32];
      out_ff.a  <= out_in.a;
      out_ff.t  <= out_in.t;
      out_ff.cs <= out_in.cs;
      out_ff.sn <= out_in.sn;
   end

   assign out_term = out_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pps_divider.sv -----
`default_nettype none

module pps_divider
   import pps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  out_valid,
   output logic [QUO_BITS:0]     quo
);

   logic                valid_ff [0:DIV_STAGES-1];
   logic [NUM_W-1:0]    rem_ff   [0:DIV_STAGES-1];
   logic [DEN_W-1:0]    den_ff   [0:DIV_STAGES-1];
   logic [QUO_BITS-1:0] quo_ff   [0:DIV_STAGES-1];
   logic                ovf_ff   [0:DIV_STAGES-1];

   logic                ovf_in;
   logic [NUM_W-1:0]    rem_in [1:DIV_STAGES-1];
   logic [QUO_BITS-1:0] quo_in [1:DIV_STAGES-1];

   // quotient beyond QUO_BITS bits only needs to saturate
   assign ovf_in = (65'(num) >= {den, 32'b0});

   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
      localparam int Bit = QUO_BITS - s;
      logic [63:0] trial;
      always_comb begin
         trial     = 64'(den_ff[s-1]) << Bit;
         rem_in[s] = rem_ff[s-1];
         quo_in[s] = quo_ff[s-1];
         if (64'(rem_ff[s-1]) >= trial) begin
            rem_in[s]      = NUM_W'(64'(rem_ff[s-1]) - trial);
            quo_in[s][Bit] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) valid_ff[s] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
      rem_ff[0] <= num;
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      ovf_ff[0] <= ovf_in;
      for (int s = 1; s < DIV_STAGES; s++) begin
         rem_ff[s] <= rem_in[s];
         den_ff[s] <= den_ff[s-1];
         quo_ff[s] <= quo_in[s];
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign quo       = {ovf_ff[DIV_STAGES-1], quo_ff[DIV_STAGES-1]};

endmodule

`default_nettype wire

// ----- tb/perspective_projection_setup_checker.sv -----
`timescale 1ns / 100ps

module perspective_projection_setup_checker
   import pps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           error_count,
   output int           pending_count,
   output int           rsp_count
);

   rsp_type matrix_queue[$];

   function automatic logic [31:0] clamp32(input logic neg, input logic [63:0] mag);
      logic [31:0] r;
      if (neg) begin
         r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
      end else begin
         r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return r;
   endfunction

   function automatic rsp_type compute_matrix(input req_type rq);
      rsp_type     o;
      logic        fneg, dneg, cneg, hneg, farneg, qneg, nneg, oneg;
      logic [63:0] fmag, dmag, a, t, smag, cmag, hmag, wmag, farmag, qmag, qm, nm, omag;
      longint      nearv, farv, d, cs, sn, q;
      logic [31:0] m33;
      o = '0;
      fneg = rq.fov[15];
      fmag = fneg ? 64'(17'h10000 - {1'b0, rq.fov}) : 64'(rq.fov);
      nearv = longint'(rq.near_plane);
      farv = longint'(rq.far_plane);
      d = farv - nearv;
      dneg = d < 0;
      dmag = dneg ? 64'(-d) : 64'(d);
      if (dmag * 100 < 64'h10000) begin
         o.status = STATUS_DEPTH;
         return o;
      end
      a = fmag << 16;
      t = 64'h4000_0000;
      cs = 64'h4000_0000;
      sn = 0;
      for (int n = 1; n <= 24; n++) begin
         t = ((t * a) >> 30) / 64'(n);
         case (n & 3)
            0: cs += longint'(t);
            1: sn += longint'(t);
            2: cs -= longint'(t);
            default: sn -= longint'(t);
         endcase
      end
      smag = sn < 0 ? 64'(-sn) : 64'(sn);
      if (smag * 100 < 64'h4000_0000) begin
         o.status = STATUS_SINE;
         return o;
      end
      cneg = cs < 0;
      cmag = cneg ? 64'(-cs) : 64'(cs);
      hneg = cneg != (fneg != (sn < 0));
      hmag = (cmag << 16) / smag;
      wmag = ((cmag * 64'(rq.aspect)) << 8) / smag;
      farneg = farv < 0;
      farmag = farneg ? 64'(-farv) : 64'(farv);
      qmag = (farmag << 16) / dmag;
      m33 = clamp32(farneg != dneg, qmag);
      q = longint'($signed(m33));
      qneg = q < 0;
      qm = qneg ? 64'(-q) : 64'(q);
      nneg = nearv < 0;
      nm = nneg ? 64'(-nearv) : 64'(nearv);
      omag = (qm * nm) >> 16;
      oneg = !(qneg != nneg);
      o.status = STATUS_OK;
      o.m11 = clamp32(hneg, wmag);
      o.m22 = clamp32(hneg, hmag);
      o.m33 = m33;
      o.m43 = clamp32(oneg, omag);
      return o;
   endfunction

   assign pending_count = matrix_queue.size();

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         matrix_queue.delete();
         error_count <= 0;
         rsp_count <= 0;
      end else begin
         if (start && !busy) matrix_queue.push_back(compute_matrix(req_data));
         if (rsp_valid) begin
            rsp_count <= rsp_count + 1;
            if (matrix_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               exp_rsp = matrix_queue.pop_front();
               if (exp_rsp !== rsp_data) begin
                  $display("%0t: mismatch expected st=%0d m11=%h m22=%h m33=%h m43=%h",
                           $time, exp_rsp.status, exp_rsp.m11, exp_rsp.m22,
                           exp_rsp.m33, exp_rsp.m43);
                  $display("%0t:          actual   st=%0d m11=%h m22=%h m33=%h m43=%h",
                           $time, rsp_data.status, rsp_data.m11, rsp_data.m22,
                           rsp_data.m33, rsp_data.m43);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/perspective_projection_setup_tb.sv -----
`timescale 1ns / 100ps

module perspective_projection_setup_tb;
   import pps_pkg::*;

   localparam int LATENCY = 110;
   localparam int STALL_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count, pending_count, rsp_count;
   int      idle_cycles;
   int      request_count;
   int      sent_count;

   perspective_projection_setup u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   perspective_projection_setup_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: cycles with no request or response accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_request(input req_type rq, input bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic req_type random_request();
      req_type rq;
      int      pick;
      logic signed [31:0] span;
      rq.fov = 16'($urandom);
      rq.aspect = 16'($urandom);
      rq.near_plane = 32'($urandom);
      rq.far_plane = 32'($urandom);
      pick = $urandom_range(0, 9);
      // mostly plausible camera set-ups, some tiny fov or depth range, some raw noise
      if (pick < 6) begin
         rq.fov = 16'($urandom_range(400, 25000));
         if ($urandom_range(0, 3) == 0) rq.fov = -rq.fov;
         rq.aspect = 16'($urandom_range(0, 1024));
         rq.near_plane = 32'($urandom_range(0, 32'h0010_0000));
         span = 32'($urandom_range(0, 32'h0100_0000));
         if ($urandom_range(0, 3) == 0) span = 32'($urandom_range(0, 1400));
         rq.far_plane = rq.near_plane + span;
      end else if (pick == 6) begin
         rq.fov = 16'($signed($urandom_range(0, 300)) - 150);
      end else if (pick == 7) begin
         rq.far_plane = rq.near_plane + 32'($signed($urandom_range(0, 1400)) - 700);
      end
      return rq;
   endfunction

   initial begin
      req_type rq;
      req_type directed[$];
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      sent_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back('{16'sd12868, 16'd256, 32'sh0001_0000, 32'sh0064_0000});
      directed.push_back('{16'sh7FFF, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
      directed.push_back('{16'sh8000, 16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
      directed.push_back('{16'sd0, 16'd256, 32'sd0, 32'sh0001_0000});
      directed.push_back('{16'sd150, 16'd256, 32'sd0, 32'sh0001_0000});
      directed.push_back('{16'sd170, 16'd256, 32'sd0, 32'sh0001_0000});
      directed.push_back('{16'sd8192, 16'd256, 32'sd5, 32'sd5});
      directed.push_back('{16'sd8192, 16'd256, 32'sd0, 32'sd655});
      directed.push_back('{16'sd8192, 16'd256, 32'sd0, 32'sd656});
      directed.push_back('{16'sd8192, 16'd256, 32'sd0, -32'sd656});
      directed.push_back('{16'sd8192, 16'd0, 32'sh0001_0000, 32'sh0002_0000});
      directed.push_back('{-16'sd8192, 16'd512, -32'sh0001_0000, 32'sh0002_0000});
      directed.push_back('{16'sd2, 16'hFFFF, 32'sh0000_1000, 32'sh0000_2000});
      directed.push_back('{16'sd25736, 16'd256, 32'sh0001_0000, 32'sh0010_0000});
      directed.push_back('{16'sd8192, 16'd256, 32'sh4000_0000, 32'sh4000_0400});
      directed.push_back('{16'sd8192, 16'd256, -32'sh4000_0000, 32'sh4000_0000});
      foreach (directed[i]) send_request(directed[i], 1'b0);

      request_count = 2000;
      for (int i = 0; i < request_count; i++) begin
         rq = random_request();
         send_request(rq, i < request_count - 200);
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Ran %0d projection requests (directed edges, error codes, random views);",
               sent_count);
      $display("%0d responses checked.", rsp_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
